### src/etok_pkg.sv
// Shared types and constants for the expression tokenizer.
package etok_pkg;

	localparam int NAME_BYTES_DEF = 8;
	localparam int QUEUE_DEPTH    = 4;
	localparam int PTR_W          = $clog2(QUEUE_DEPTH);
	localparam int CNT_W          = PTR_W + 1;
	localparam int TDATA_W        = 120;

	localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

	typedef enum logic [4:0] {
		T_INT    = 5'd0,
		T_PLUS   = 5'd1,
		T_MINUS  = 5'd2,
		T_STAR   = 5'd3,
		T_SLASH  = 5'd4,
		T_LPAREN = 5'd5,
		T_RPAREN = 5'd6,
		T_EOF    = 5'd7,
		T_IDENT  = 5'd8,
		T_LET    = 5'd9,
		T_EQ     = 5'd10,
		T_SEMI   = 5'd11,
		T_IF     = 5'd12,
		T_ELSE   = 5'd13,
		T_TRUE   = 5'd14,
		T_FALSE  = 5'd15,
		T_LT     = 5'd16,
		T_GT     = 5'd17,
		T_EQEQ   = 5'd18,
		T_LBRACE = 5'd19,
		T_RBRACE = 5'd20,
		T_FN     = 5'd21,
		T_COMMA  = 5'd22,
		T_RETURN = 5'd23,
		T_ERROR  = 5'd24
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [30:0] num_value;
		logic        int_overflow;
		logic [63:0] ident_text;
		logic [7:0]  ident_length;
		logic        ident_truncated;
		logic [7:0]  offending_char;
		logic        last;
	} tok_t;

endpackage

### src/etok_scan.sv
// Character scanner: mode state, number and name accumulation, token decode.
module etok_scan #(
	parameter int NAME_BYTES = etok_pkg::NAME_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     char_in,
	output logic [1:0]     tok_count,
	output etok_pkg::tok_t tok0,
	output etok_pkg::tok_t tok1
);

	localparam int BUF_W = 8 * NAME_BYTES;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_Z_UP   = 8'h5A;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_Z_LO   = 8'h7A;

	// keywords, first character in the lowest byte
	localparam logic [63:0] KW_LET    = 64'h0000_0000_0074_656C;
	localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_ELSE   = 64'h0000_0000_6573_6C65;
	localparam logic [63:0] KW_TRUE   = 64'h0000_0000_6575_7274;
	localparam logic [63:0] KW_FALSE  = 64'h0000_0065_736C_6166;
	localparam logic [63:0] KW_FN     = 64'h0000_0000_0000_6E66;
	localparam logic [63:0] KW_RETURN = 64'h0000_6E72_7574_6572;

	typedef enum logic [2:0] {
		M_IDLE,
		M_NUM,
		M_NAME,
		M_EQ,
		M_ERR
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [30:0]      acc_q, acc_d;
	logic             ovf_q, ovf_d;
	logic [BUF_W-1:0] name_q, name_d;
	logic [7:0]       len_q, len_d;

	logic             is_digit, is_alpha, is_space, is_single;
	etok_pkg::tok_kind_t single_kind;
	logic [34:0]      acc_next;
	logic             acc_sat;
	logic [63:0]      text64;
	logic             name_trunc;
	etok_pkg::tok_t   name_tok;
	etok_pkg::tok_t   pend_tok, new_tok;
	logic             has_pend, has_new, fin;

	assign is_digit = (char_in >= CH_0) && (char_in <= CH_9);
	assign is_alpha = ((char_in >= CH_A_LO) && (char_in <= CH_Z_LO)) ||
		((char_in >= CH_A_UP) && (char_in <= CH_Z_UP));
	assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));

	always_comb begin
		is_single   = 1'b1;
		single_kind = etok_pkg::T_ERROR;
		unique case (char_in)
			CH_PLUS:   single_kind = etok_pkg::T_PLUS;
			CH_MINUS:  single_kind = etok_pkg::T_MINUS;
			CH_STAR:   single_kind = etok_pkg::T_STAR;
			CH_SLASH:  single_kind = etok_pkg::T_SLASH;
			CH_LPAREN: single_kind = etok_pkg::T_LPAREN;
			CH_RPAREN: single_kind = etok_pkg::T_RPAREN;
			CH_SEMI:   single_kind = etok_pkg::T_SEMI;
			CH_LT:     single_kind = etok_pkg::T_LT;
			CH_GT:     single_kind = etok_pkg::T_GT;
			CH_LBRACE: single_kind = etok_pkg::T_LBRACE;
			CH_RBRACE: single_kind = etok_pkg::T_RBRACE;
			CH_COMMA:  single_kind = etok_pkg::T_COMMA;
			default:   is_single = 1'b0;
		endcase
	end

	// acc * 10 + digit
	assign acc_next = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(char_in[3:0]);
	assign acc_sat  = acc_next > 35'(etok_pkg::INT_MAX31);

	assign text64     = 64'(name_q);
	assign name_trunc = len_q > 8'(NAME_BYTES);

	always_comb begin
		name_tok = '0;
		name_tok.kind = etok_pkg::T_IDENT;
		name_tok.ident_text = text64;
		name_tok.ident_length = len_q;
		name_tok.ident_truncated = name_trunc;
		if (!name_trunc) begin
			if (len_q == 8'd3 && text64 == KW_LET) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_LET;
			end else if (len_q == 8'd2 && text64 == KW_IF) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_IF;
			end else if (len_q == 8'd4 && text64 == KW_ELSE) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_ELSE;
			end else if (len_q == 8'd4 && text64 == KW_TRUE) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_TRUE;
			end else if (len_q == 8'd5 && text64 == KW_FALSE) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_FALSE;
			end else if (len_q == 8'd2 && text64 == KW_FN) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_FN;
			end else if (len_q == 8'd6 && text64 == KW_RETURN) begin
				name_tok = '0;
				name_tok.kind = etok_pkg::T_RETURN;
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		name_d   = name_q;
		len_d    = len_q;
		pend_tok = '0;
		new_tok  = '0;
		has_pend = 1'b0;
		has_new  = 1'b0;
		fin      = 1'b0;

		// close out whatever token is in progress
		unique case (mode_q)
			M_ERR: begin
				fin = 1'b1;
				if (char_in == CH_NUL) begin
					has_pend = 1'b1;
					pend_tok.kind = etok_pkg::T_EOF;
					mode_d = M_IDLE;
					acc_d  = '0;
					ovf_d  = 1'b0;
					name_d = '0;
					len_d  = '0;
				end
			end
			M_NUM: begin
				if (is_digit) begin
					fin = 1'b1;
					if (acc_sat) begin
						acc_d = etok_pkg::INT_MAX31;
						ovf_d = 1'b1;
					end else begin
						acc_d = acc_next[30:0];
					end
				end else begin
					has_pend = 1'b1;
					pend_tok.kind = etok_pkg::T_INT;
					pend_tok.num_value = acc_q;
					pend_tok.int_overflow = ovf_q;
					mode_d = M_IDLE;
				end
			end
			M_NAME: begin
				if (is_alpha || is_digit || char_in == CH_UNDER) begin
					fin = 1'b1;
					for (int b = 0; b < NAME_BYTES; b++) begin
						if (len_q == 8'(b))
							name_d[8*b +: 8] = char_in;
					end
					if (len_q != 8'hFF)
						len_d = len_q + 8'd1;
				end else begin
					has_pend = 1'b1;
					pend_tok = name_tok;
					mode_d = M_IDLE;
				end
			end
			M_EQ: begin
				has_pend = 1'b1;
				mode_d = M_IDLE;
				if (char_in == CH_EQUALS) begin
					pend_tok.kind = etok_pkg::T_EQEQ;
					fin = 1'b1;
				end else begin
					pend_tok.kind = etok_pkg::T_EQ;
				end
			end
			default: ;
		endcase

		// the character on its own
		if (!fin) begin
			if (is_space) begin
				has_new = 1'b0;
			end else if (is_single) begin
				has_new = 1'b1;
				new_tok.kind = single_kind;
			end else if (char_in == CH_EQUALS) begin
				mode_d = M_EQ;
			end else if (char_in == CH_NUL) begin
				has_new = 1'b1;
				new_tok.kind = etok_pkg::T_EOF;
				mode_d = M_IDLE;
				acc_d  = '0;
				ovf_d  = 1'b0;
				name_d = '0;
				len_d  = '0;
			end else if (is_digit) begin
				mode_d = M_NUM;
				acc_d  = 31'(char_in[3:0]);
				ovf_d  = 1'b0;
			end else if (is_alpha || char_in == CH_UNDER) begin
				mode_d = M_NAME;
				name_d = BUF_W'(char_in);
				len_d  = 8'd1;
			end else begin
				has_new = 1'b1;
				new_tok.kind = etok_pkg::T_ERROR;
				new_tok.offending_char = char_in;
				mode_d = M_ERR;
			end
		end
	end

	always_comb begin
		tok0 = '0;
		tok1 = '0;
		tok_count = 2'd0;
		if (has_pend && has_new) begin
			tok0 = pend_tok;
			tok1 = new_tok;
			tok1.last = 1'b1;
			tok_count = 2'd2;
		end else if (has_pend) begin
			tok0 = pend_tok;
			tok0.last = 1'b1;
			tok_count = 2'd1;
		end else if (has_new) begin
			tok0 = new_tok;
			tok0.last = 1'b1;
			tok_count = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			name_q <= '0;
			len_q  <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			ovf_q  <= ovf_d;
			name_q <= name_d;
			len_q  <= len_d;
		end
	end

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_ERR && char_in != CH_NUL) |-> tok_count == 2'd0)
		else $error("tokens emitted while ignoring input");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_count == 2'd2) |-> (tok1.last && !tok0.last))
		else $error("bad last marking on token pair");

	a_sat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && mode_q == M_NUM && ovf_q && is_digit) |=> acc_q == etok_pkg::INT_MAX31)
		else $error("saturated number left its ceiling");

endmodule

### src/etok_fifo.sv
// Token queue between the scanner and the output stream, up to two writes per cycle.
module etok_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  etok_pkg::tok_t din0,
	input  etok_pkg::tok_t din1,
	input  logic           pop,
	output etok_pkg::tok_t dout,
	output logic           not_empty,
	output logic           room_two
);

	etok_pkg::tok_t mem_q [etok_pkg::QUEUE_DEPTH];

	logic [etok_pkg::PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [etok_pkg::CNT_W-1:0] cnt_q;

	assign dout      = mem_q[rd_ptr_q];
	assign not_empty = cnt_q != '0;
	assign room_two  = cnt_q <= etok_pkg::CNT_W'(etok_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= din0;
		if (push_n == 2'd2)
			mem_q[wr_ptr_q + etok_pkg::PTR_W'(1)] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (pop)
				rd_ptr_q <= rd_ptr_q + etok_pkg::PTR_W'(1);
			wr_ptr_q <= wr_ptr_q + etok_pkg::PTR_W'(push_n);
			cnt_q    <= cnt_q + etok_pkg::CNT_W'(push_n) - etok_pkg::CNT_W'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q + etok_pkg::CNT_W'(push_n) - etok_pkg::CNT_W'(pop))
			<= etok_pkg::CNT_W'(etok_pkg::QUEUE_DEPTH))
		else $error("token queue overrun");

endmodule

### src/expression_tokenizer_core.sv
// Top level of the expression tokenizer: input register, scanner, token queue.
// One character is taken per clock cycle unless the token queue holds input off. A character
// is registered on accept and scanned from that register once the queue has room for two
// tokens; any token it completes is written into the queue and shown on the master side. A
// character can close a pending number, name or '=' and also give its own token, so it may
// yield two output requests; these pass through a four-entry token queue, and input is held
// off only while that queue has fewer than two free entries. A drain of one token per cycle
// keeps the input at full rate as long as the stream averages at most one token per character.
module expression_tokenizer_core #(
	parameter int NAME_BYTES = etok_pkg::NAME_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // char_in
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// num_value, int_overflow, ident_text, ident_length, ident_truncated, offending_char,
	// zero fill
	output logic [etok_pkg::TDATA_W-1:0] m_tdata,
	output logic [4:0]                   m_tuser,  // token_kind
	output logic                         m_tlast
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           advance;
	logic           room_two;
	logic [1:0]     tok_count;
	logic [1:0]     push_n;
	etok_pkg::tok_t tok0, tok1, head;

	assign advance  = valid_s1 && room_two;
	assign s_tready = !valid_s1 || room_two;
	assign push_n   = advance ? tok_count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			char_s1 <= s_tdata;
	end

	etok_scan #(
		.NAME_BYTES(NAME_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_in   (char_s1),
		.tok_count (tok_count),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	etok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.din0      (tok0),
		.din1      (tok1),
		.pop       (m_tvalid && m_tready),
		.dout      (head),
		.not_empty (m_tvalid),
		.room_two  (room_two)
	);

	assign m_tdata = {7'b000_0000, head.offending_char, head.ident_truncated, head.ident_length,
		head.ident_text, head.int_overflow, head.num_value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1)))
		else $error("registered character lost while stalled");

endmodule

### tb/token_checker.sv
// Token checker: predicts tokenizer output from accepted characters and compares it field by field.
module token_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [etok_pkg::TDATA_W-1:0] m_tdata,
	input  logic [4:0]                   m_tuser,
	input  logic                         m_tlast,
	output int                           backlog,
	output int                           errors
);

	localparam int NB = etok_pkg::NAME_BYTES_DEF;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_NUM,
		SCAN_NAME,
		SCAN_EQ,
		SCAN_ERR
	} scan_t;

	scan_t               mode      = SCAN_IDLE;
	logic [30:0]         num_acc   = '0;
	logic                num_sat   = 1'b0;
	logic [63:0]         name_text = '0;
	logic [7:0]          name_len  = '0;
	etok_pkg::tok_t      expected_tokens[$];
	string               kw_words[7] = '{"let", "if", "else", "true", "false", "fn", "return"};
	etok_pkg::tok_kind_t kw_kinds[7] = '{etok_pkg::T_LET, etok_pkg::T_IF, etok_pkg::T_ELSE,
		etok_pkg::T_TRUE, etok_pkg::T_FALSE, etok_pkg::T_FN, etok_pkg::T_RETURN};

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit blank_char(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic etok_pkg::tok_t bare(etok_pkg::tok_kind_t k);
		etok_pkg::tok_t t;
		t = '0;
		t.kind = k;
		return t;
	endfunction

	function automatic bit punct_kind(input logic [7:0] c, output etok_pkg::tok_kind_t k);
		k = etok_pkg::T_ERROR;
		punct_kind = 1'b1;
		case (c)
			"+": k = etok_pkg::T_PLUS;
			"-": k = etok_pkg::T_MINUS;
			"*": k = etok_pkg::T_STAR;
			"/": k = etok_pkg::T_SLASH;
			"(": k = etok_pkg::T_LPAREN;
			")": k = etok_pkg::T_RPAREN;
			";": k = etok_pkg::T_SEMI;
			"<": k = etok_pkg::T_LT;
			">": k = etok_pkg::T_GT;
			"{": k = etok_pkg::T_LBRACE;
			"}": k = etok_pkg::T_RBRACE;
			",": k = etok_pkg::T_COMMA;
			default: punct_kind = 1'b0;
		endcase
	endfunction

	// keyword match only for names that were not cut short
	function automatic etok_pkg::tok_t name_token();
		etok_pkg::tok_t t;
		logic [63:0] word;
		if (name_len <= NB) begin
			for (int i = 0; i < 7; i++) begin
				word = '0;
				for (int j = 0; j < kw_words[i].len(); j++)
					word |= 64'(kw_words[i][j]) << (8 * j);
				if (name_len == kw_words[i].len() && name_text == word)
					return bare(kw_kinds[i]);
			end
		end
		t = bare(etok_pkg::T_IDENT);
		t.ident_text = name_text;
		t.ident_length = name_len;
		t.ident_truncated = name_len > NB;
		return t;
	endfunction

	task automatic clear_scan();
		mode = SCAN_IDLE;
		num_acc = '0;
		num_sat = 1'b0;
		name_text = '0;
		name_len = '0;
	endtask

	task automatic predict_char(logic [7:0] c);
		etok_pkg::tok_t      toks[$];
		etok_pkg::tok_t      t;
		etok_pkg::tok_kind_t k;
		logic [63:0]         v;
		bit                  taken;
		taken = 1'b0;
		if (mode == SCAN_ERR) begin
			taken = 1'b1;
			if (c == 8'h00) begin
				toks.push_back(bare(etok_pkg::T_EOF));
				clear_scan();
			end
		end else if (mode == SCAN_NUM) begin
			if (digit_char(c)) begin
				v = 64'(num_acc) * 64'd10 + 64'(c - "0");
				if (v > 64'(etok_pkg::INT_MAX31)) begin
					v = 64'(etok_pkg::INT_MAX31);
					num_sat = 1'b1;
				end
				num_acc = v[30:0];
				taken = 1'b1;
			end else begin
				t = bare(etok_pkg::T_INT);
				t.num_value = num_acc;
				t.int_overflow = num_sat;
				toks.push_back(t);
				mode = SCAN_IDLE;
			end
		end else if (mode == SCAN_NAME) begin
			if (letter_char(c) || digit_char(c) || c == "_") begin
				if (name_len < NB)
					name_text |= 64'(c) << (8 * name_len);
				if (name_len < 8'd255)
					name_len++;
				taken = 1'b1;
			end else begin
				toks.push_back(name_token());
				mode = SCAN_IDLE;
			end
		end else if (mode == SCAN_EQ) begin
			mode = SCAN_IDLE;
			if (c == "=") begin
				toks.push_back(bare(etok_pkg::T_EQEQ));
				taken = 1'b1;
			end else begin
				toks.push_back(bare(etok_pkg::T_EQ));
			end
		end
		if (!taken) begin
			if (blank_char(c)) begin
			end else if (punct_kind(c, k)) begin
				toks.push_back(bare(k));
			end else if (c == "=") begin
				mode = SCAN_EQ;
			end else if (c == 8'h00) begin
				toks.push_back(bare(etok_pkg::T_EOF));
				clear_scan();
			end else if (digit_char(c)) begin
				mode = SCAN_NUM;
				num_acc = 31'(c - "0");
				num_sat = 1'b0;
			end else if (letter_char(c) || c == "_") begin
				mode = SCAN_NAME;
				name_text = 64'(c);
				name_len = 8'd1;
			end else begin
				t = bare(etok_pkg::T_ERROR);
				t.offending_char = c;
				toks.push_back(t);
				mode = SCAN_ERR;
			end
		end
		if (toks.size() > 0)
			toks[toks.size() - 1].last = 1'b1;
		foreach (toks[i])
			expected_tokens.push_back(toks[i]);
	endtask

	task automatic report_mismatch(string msg);
		if (errors < 20)
			$display("token mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic compare_token();
		etok_pkg::tok_t got;
		etok_pkg::tok_t want;
		got.kind = etok_pkg::tok_kind_t'(m_tuser);
		got.num_value = m_tdata[30:0];
		got.int_overflow = m_tdata[31];
		got.ident_text = m_tdata[95:32];
		got.ident_length = m_tdata[103:96];
		got.ident_truncated = m_tdata[104];
		got.offending_char = m_tdata[112:105];
		got.last = m_tlast;
		if (expected_tokens.size() == 0) begin
			report_mismatch($sformatf("token of kind %0d with none expected", got.kind));
		end else begin
			want = expected_tokens.pop_front();
			check_field("kind", got.kind, want.kind);
			check_field("num_value", got.num_value, want.num_value);
			check_field("int_overflow", got.int_overflow, want.int_overflow);
			check_field("ident_text", got.ident_text, want.ident_text);
			check_field("ident_length", got.ident_length, want.ident_length);
			check_field("ident_truncated", got.ident_truncated, want.ident_truncated);
			check_field("offending_char", got.offending_char, want.offending_char);
			check_field("last", got.last, want.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				compare_token();
			if (s_tvalid && s_tready)
				predict_char(s_tdata);
		end
		backlog <= expected_tokens.size();
	end

endmodule

### tb/testbench.sv
// Tokenizer testbench top: clock, reset, character stimulus, output back-pressure and verdict.
module testbench;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [etok_pkg::TDATA_W-1:0] m_tdata;
	logic [4:0]                   m_tuser;
	logic                         m_tlast;
	int                           backlog;
	int                           errors;
	int                           sent_count = 0;
	logic                         steady   = 1'b0;
	logic                         hold_off = 1'b0;
	bit                           long_name_sent = 1'b0;
	string kw_words[7] = '{"let", "if", "else", "true", "false", "fn", "return"};
	string punct_set = "+-*/(){}<>,;";

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	expression_tokenizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	token_checker tok_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.backlog  (backlog),
		.errors   (errors)
	);

	always @(posedge clk) begin
		m_tready <= !hold_off && (steady || $urandom_range(99) >= 12);
	end

	// long sink stall mid-run so the token queue fills and input backs up
	initial begin
		wait (sent_count >= 500);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#200000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic send_char(logic [7:0] c);
		if (!steady && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] name_char(bit lead);
		int r;
		r = $urandom_range(lead ? 52 : 62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] blank_pick();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? 8'h20 : 8'(9 + r);
	endfunction

	task automatic send_random_line();
		int    n_tok;
		int    pick;
		int    len;
		int    r;
		string w;
		n_tok = $urandom_range(1, 10);
		for (int i = 0; i < n_tok; i++) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				send_char(8'($urandom_range(255)));
			end else if (pick < 20) begin
				w = kw_words[$urandom_range(6)];
				r = $urandom_range(9);
				if (r == 1)
					w[0] = 8'(w[0] - 32);
				send_text(w);
				if (r == 0)
					send_char(name_char(1'b0));
			end else if (pick < 40) begin
				len = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 16);
				if (!long_name_sent && sent_count > 300) begin
					len = 270;
					long_name_sent = 1'b1;
				end
				send_char(name_char(1'b1));
				for (int j = 1; j < len; j++)
					send_char(name_char(1'b0));
			end else if (pick < 58) begin
				r = $urandom_range(9);
				len = (r < 7) ? $urandom_range(1, 5) :
					(r < 9) ? $urandom_range(6, 9) : $urandom_range(10, 12);
				for (int j = 0; j < len; j++)
					send_char(8'("0" + $urandom_range(9)));
			end else if (pick < 92) begin
				r = $urandom_range(13);
				if (r < 12)
					send_char(punct_set[r]);
				else if (r == 12)
					send_char("=");
				else
					send_text("==");
			end else begin
				send_char(blank_pick());
			end
			if ($urandom_range(1))
				send_char(blank_pick());
		end
		send_char(8'h00);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// closing a name on '=', EQEQ, saturating number closed by a punctuator
		send_text("_z==9999999999;");
		send_text("(+-*/){}<>,=");
		send_char(8'h09);
		send_char(8'h00);
		// unknown character, ignored input, then end of line
		send_char(8'hFF);
		send_char("a");
		send_char(8'h00);
		while (sent_count < 1400) begin
			steady <= (sent_count >= 800 && sent_count < 1100);
			send_random_line();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

### sim.f
src/etok_pkg.sv
src/etok_scan.sv
src/etok_fifo.sv
src/expression_tokenizer_core.sv
tb/token_checker.sv
tb/testbench.sv
